// File: hdl/puwbg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bus gate package
// Shared sizes, types and codes of the per-unit window bus gate.
// ----------------------------------------------------------------------------
package puwbg_pkg;

    localparam int SLOTS = 8;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    localparam cnt_t CNT_FULL = cnt_t'(SLOTS);

    localparam logic OP_REGISTER = 1'b0;
    localparam logic OP_REQUEST  = 1'b1;

    typedef struct packed {
        logic [15:0] unit;
        logic [31:0] window;
        logic [31:0] last;
    } entry_t;

    typedef struct packed {
        logic   rd_en;
        idx_t   rd_addr;
        logic   wr_en;
        idx_t   wr_addr;
        entry_t wr_data;
    } mem_req_t;

    typedef struct packed {
        logic        granted;
        logic [3:0]  active_slots;
        logic [31:0] rejected_count;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_COMPARE,
        ST_DECIDE,
        ST_RESP
    } state_t;

endpackage
`default_nettype wire

// File: hdl/puwbg_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bus gate unit table
// Storage for unit id, window and last grant time, one write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
module puwbg_table
(
    input  wire logic              clk,
    input  wire puwbg_pkg::mem_req_t req,
    output      puwbg_pkg::entry_t rd_data
);
    import puwbg_pkg::*;

    entry_t mem [SLOTS];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// File: hdl/puwbg_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bus gate sequencer
// Scans the unit table one entry at a time with a shared id compare, then
// applies the window check and updates the table, count and reject total.
// ----------------------------------------------------------------------------
module puwbg_seq
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output      logic               in_stall,
    input  wire logic               operation,
    input  wire logic [15:0]        unit_id,
    input  wire logic [31:0]        window_ms,
    input  wire logic [31:0]        now_ms,
    input  wire logic               bus_available,
    input  wire logic               out_free,
    output      logic               res_load,
    output      puwbg_pkg::result_t res,
    output      puwbg_pkg::mem_req_t mem_req,
    input  wire puwbg_pkg::entry_t  rd_data
);
    import puwbg_pkg::*;

    state_t state_reg, state_next;

    logic        op_reg;
    logic [15:0] id_reg;
    logic [31:0] win_reg;
    logic [31:0] now_reg;
    logic        avail_reg;

    idx_t        idx_reg, idx_next;
    logic        hit_reg, hit_next;
    cnt_t        count_reg, count_next;
    logic [31:0] reject_reg, reject_next;
    logic        granted_reg, granted_next;

    logic        accept;
    logic        match;
    logic        last_slot;
    logic [31:0] elapsed;
    logic        too_early;
    logic        do_set_window;
    logic        do_append;
    logic        do_stamp;
    logic        grant;
    logic        reject;
    logic [31:0] count_wide;

    assign accept    = (state_reg == ST_IDLE) && in_valid;
    assign match     = (rd_data.unit == id_reg);
    assign last_slot = ((cnt_t'(idx_reg) + cnt_t'(1)) == count_reg);
    assign elapsed   = now_reg - rd_data.last;
    assign too_early = (elapsed < rd_data.window);

    // Outcome of the item once the scan has settled on hit or miss.
    always_comb
    begin
        do_set_window = 1'b0;
        do_append     = 1'b0;
        do_stamp      = 1'b0;
        grant         = 1'b0;
        reject        = 1'b0;
        if (op_reg == OP_REGISTER)
        begin
            if (win_reg != 32'd0)
            begin
                if (hit_reg)
                begin
                    do_set_window = 1'b1;
                end
                else if (count_reg < CNT_FULL)
                begin
                    do_append = 1'b1;
                end
            end
        end
        else
        begin
            if (!hit_reg)
            begin
                grant  = avail_reg;
                reject = !avail_reg;
            end
            else if (too_early || !avail_reg)
            begin
                reject = 1'b1;
            end
            else
            begin
                do_stamp = 1'b1;
                grant    = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (count_reg == cnt_t'(0)) ? ST_DECIDE : ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_COMPARE;
            end
            ST_COMPARE:
            begin
                state_next = (match || last_slot) ? ST_DECIDE : ST_LOOKUP;
            end
            ST_DECIDE:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall         = 1'b1;
        res_load         = 1'b0;
        mem_req.rd_en    = 1'b0;
        mem_req.rd_addr  = idx_reg;
        mem_req.wr_en    = 1'b0;
        mem_req.wr_addr  = idx_reg;
        mem_req.wr_data  = rd_data;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_LOOKUP:
            begin
                mem_req.rd_en = 1'b1;
            end
            ST_COMPARE:
            begin
            end
            ST_DECIDE:
            begin
                if (do_set_window)
                begin
                    mem_req.wr_en          = 1'b1;
                    mem_req.wr_data.window = win_reg;
                end
                else if (do_stamp)
                begin
                    mem_req.wr_en        = 1'b1;
                    mem_req.wr_data.last = now_reg;
                end
                else if (do_append)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = count_reg[IDX_W-1:0];
                    mem_req.wr_data = '{unit: id_reg, window: win_reg, last: 32'd0};
                end
            end
            ST_RESP:
            begin
                res_load = out_free;
            end
            default:
            begin
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        idx_next     = idx_reg;
        hit_next     = hit_reg;
        count_next   = count_reg;
        reject_next  = reject_reg;
        granted_next = granted_reg;
        if (accept)
        begin
            idx_next = '0;
            hit_next = 1'b0;
        end
        if (state_reg == ST_COMPARE)
        begin
            if (match)
            begin
                hit_next = 1'b1;
            end
            else if (!last_slot)
            begin
                idx_next = idx_reg + idx_t'(1);
            end
        end
        if (state_reg == ST_DECIDE)
        begin
            granted_next = grant;
            if (do_append)
            begin
                count_next = count_reg + cnt_t'(1);
            end
            if (reject)
            begin
                reject_next = reject_reg + 32'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            hit_reg     <= 1'b0;
            count_reg   <= '0;
            reject_reg  <= '0;
            granted_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            hit_reg     <= hit_next;
            count_reg   <= count_next;
            reject_reg  <= reject_next;
            granted_reg <= granted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= operation;
            id_reg    <= unit_id;
            win_reg   <= window_ms;
            now_reg   <= now_ms;
            avail_reg <= bus_available;
        end
    end

    // The reported count is the slot count truncated to four bits.
    assign count_wide         = 32'(count_reg);
    assign res.granted        = granted_reg;
    assign res.active_slots   = count_wide[3:0];
    assign res.rejected_count = reject_reg;

endmodule
`default_nettype wire

// File: hdl/per_unit_window_bus_gate_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Per-unit window bus gate
// Grants the bus, when it is available, to a registered unit only after its window
// since its last grant has passed, to an unknown unit at once, and keeps the unit table and a reject total.
// ----------------------------------------------------------------------------
//  Channel   Handshake           Payload
//  input     in_valid/in_stall   operation, unit_id, window_ms, now_ms,
//                                bus_available
//  output    out_valid/out_stall granted, active_slots, rejected_count
//
// An item goes from IDLE through LOOKUP and COMPARE once per table entry scanned
// (at most the number of registered units), then through DECIDE and RESP:
// the table has one registered read port, so each entry costs a read state
// and a compare state. Reset clears the unit count, the reject total and all
// control; table contents are written before they are read. A result waits
// in the output register while the next item is taken in; the sequencer
// holds its result only when that register is still full and stalled.
// ----------------------------------------------------------------------------
module per_unit_window_bus_gate_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output      logic        in_stall,
    input  wire logic        operation,
    input  wire logic [15:0] unit_id,
    input  wire logic [31:0] window_ms,
    input  wire logic [31:0] now_ms,
    input  wire logic        bus_available,
    output      logic        out_valid,
    input  wire logic        out_stall,
    output      logic        granted,
    output      logic [3:0]  active_slots,
    output      logic [31:0] rejected_count
);
    import puwbg_pkg::*;

    mem_req_t    mem_req;
    entry_t      rd_data;
    result_t     res;
    logic        res_load;
    logic        out_free;

    logic        out_valid_reg, out_valid_next;
    logic        granted_reg;
    logic [3:0]  active_reg;
    logic [31:0] rejected_reg;

    assign out_free = !out_valid_reg || !out_stall;

    puwbg_table u_table
    (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    puwbg_seq u_seq
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .unit_id       (unit_id),
        .window_ms     (window_ms),
        .now_ms        (now_ms),
        .bus_available (bus_available),
        .out_free      (out_free),
        .res_load      (res_load),
        .res           (res),
        .mem_req       (mem_req),
        .rd_data       (rd_data)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            granted_reg  <= res.granted;
            active_reg   <= res.active_slots;
            rejected_reg <= res.rejected_count;
        end
    end

    assign out_valid      = out_valid_reg;
    assign granted        = granted_reg;
    assign active_slots   = active_reg;
    assign rejected_count = rejected_reg;

endmodule
`default_nettype wire
